// ===== rtl/rqt_pkg.sv =====
// Shared types and constants for the retransmit queue table.
package rqt_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int PADDR_W  = 3;

  localparam logic [PADDR_W-3:0] REG_TIMEOUT = '0;
  localparam logic [31:0]        TIMEOUT_RST = 32'd1000;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_FIND    = 2'd2,
    OP_TIMEOUT = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] seq_number;
    logic [31:0] send_time;
    logic [31:0] current_time;
    logic [15:0] entry_tag;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] out_seq;
    logic [31:0] out_time;
    logic [15:0] out_tag;
    logic [4:0]  entries_held;
  } out_item_t;

  typedef struct packed {
    logic [31:0]         seq;
    logic [31:0]         stime;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ===== rtl/rqt_store.sv =====
// Entry memory: one write port, one registered read port.
module rqt_store
  import rqt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  input  entry_t   wr_data,
  output entry_t   rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/rqt_cmp.sv =====
// Shared compare unit: sequence match or wrapped age against the timeout.
module rqt_cmp
  import rqt_pkg::*;
(
  input  logic        age_mode,
  input  logic [31:0] key_seq,
  input  logic [31:0] now,
  input  logic [31:0] timeout_ticks,
  input  entry_t      entry,
  output logic        hit
);

  logic [31:0] age;

  // modulo 2^32 difference, so a wrapped clock still gives the right age
  assign age = now - entry.stime;
  assign hit = age_mode ? (age >= timeout_ticks) : (entry.seq == key_seq);

endmodule

// ===== rtl/retransmit_queue_table.sv =====
// Top level of the retransmit queue table: sequencer, registers and ports.
//
// Holds up to DEPTH unacknowledged packets (sequence, send time, tag) in
// insertion order. One input item carries an opcode: add, remove by
// sequence, find by sequence or timeout check. Every item gives exactly one
// result item with a status, the entry concerned and the fill level after it.
// Both channels use valid/stall; an item moves when valid is high and stall
// low. in_stall is high whenever an item is in work, one item at a time.
// An add, a full add or any operation on an empty table goes straight to
// the done state. Find, remove and timeout walk the entries one per cycle
// through the single memory read port and the shared compare unit, and
// stop at the first entry that decides, or after the last one on a miss.
// A remove that hits before the last entry then moves each later entry
// down one slot, one per cycle over the same read port. The next item is
// taken in the cycle after the result loads.
// A stalled result holds in the output register; a finished item waits in
// the done state until that register frees, and the next item is taken then.
// Reset (synchronous, rst_n low) empties the table and sets timeout_ticks to
// 1000; the memory itself is not cleared. timeout_ticks sits at APB address
// 0 and should be written only while the block is idle.
module retransmit_queue_table
  import rqt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // item input
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  // result output
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  state_t state_r, state_nxt;

  opcode_t     op_r, op_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] tmo_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [CNT_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [CNT_W-1:0] last_idx;

  status_t res_status_r, res_status_nxt;
  entry_t  res_entry_r, res_entry_nxt;

  out_item_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  mem_req_t req;
  entry_t   wr_data;
  entry_t   rd_data;
  logic     hit;
  logic     slot_free;
  logic     in_take;

  // ---------------------------------------------------------------
  // APB register: timeout_ticks
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_TIMEOUT) ? tmo_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_TIMEOUT) begin
      tmo_r <= pwdata;
    end
  end

  // ---------------------------------------------------------------
  // Entry memory and shared compare unit
  // ---------------------------------------------------------------
  rqt_store u_store (
    .clk     (clk),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  rqt_cmp u_cmp (
    .age_mode      (op_r == OP_TIMEOUT),
    .key_seq       (key_r),
    .now           (now_r),
    .timeout_ticks (tmo_r),
    .entry         (rd_data),
    .hit           (hit)
  );

  assign last_idx  = count_r - CNT_W'(1);
  assign slot_free = !out_valid_r || !out_stall;
  assign in_take   = in_valid && (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.opcode == OP_ADD || count_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pend_r && hit) begin
          if (op_r == OP_REMOVE && pend_idx_r != last_idx) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (pend_r && pend_idx_r == last_idx) begin
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        if (pend_r && pend_idx_r == last_idx) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Datapath and memory control
  // ---------------------------------------------------------------
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    now_nxt        = now_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    res_status_nxt = res_status_r;
    res_entry_nxt  = res_entry_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    req            = '0;
    wr_data        = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_nxt         = in_data.opcode;
          key_nxt        = in_data.seq_number;
          now_nxt        = in_data.current_time;
          idx_nxt        = '0;
          res_entry_nxt  = '0;
          res_status_nxt = ST_NONE;
          if (in_data.opcode == OP_ADD) begin
            if (count_r == CNT_W'(DEPTH)) begin
              res_status_nxt = ST_FULL;
            end else begin
              wr_data.seq    = in_data.seq_number;
              wr_data.stime  = in_data.send_time;
              wr_data.tag    = TAG_BITS'(in_data.entry_tag);
              req.wr_en      = 1'b1;
              req.wr_addr    = count_r[IDX_W-1:0];
              count_nxt      = count_r + CNT_W'(1);
              res_status_nxt = ST_OK;
              res_entry_nxt  = wr_data;
            end
          end
        end
      end
      S_SCAN: begin
        // one read issued per cycle, compared the cycle after
        if (idx_r < count_r) begin
          req.rd_en    = 1'b1;
          req.rd_addr  = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
        end
        if (pend_r && hit) begin
          res_status_nxt = ST_OK;
          res_entry_nxt  = rd_data;
          pend_nxt       = 1'b0;
          if (op_r == OP_REMOVE) begin
            if (pend_idx_r == last_idx) begin
              count_nxt = count_r - CNT_W'(1);
            end else begin
              idx_nxt = pend_idx_r + CNT_W'(1);
            end
          end
        end else if (pend_r && pend_idx_r == last_idx) begin
          res_status_nxt = ST_NONE;
          res_entry_nxt  = '0;
        end
      end
      S_SHIFT: begin
        // read slot j, write it into slot j-1 next cycle
        if (idx_r < count_r) begin
          req.rd_en    = 1'b1;
          req.rd_addr  = idx_r[IDX_W-1:0];
          idx_nxt      = idx_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r;
        end
        if (pend_r) begin
          req.wr_en   = 1'b1;
          req.wr_addr = IDX_W'(pend_idx_r - CNT_W'(1));
          if (pend_idx_r == last_idx) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.status       = res_status_r;
          out_nxt.out_seq      = res_entry_r.seq;
          out_nxt.out_time     = res_entry_r.stime;
          out_nxt.out_tag      = 16'(res_entry_r.tag);
          out_nxt.entries_held = 5'(count_r);
        end
      end
      default: begin
        pend_nxt = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    res_status_r <= res_status_nxt;
    res_entry_r  <= res_entry_nxt;
    out_r        <= out_nxt;
  end

endmodule

// ===== sim/retransmit_queue_table_tb.sv =====
// Self-checking testbench for the retransmit queue table: random and directed items.
module retransmit_queue_table_tb;
  import rqt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any item moving before the run is declared hung; the
  // slowest item is a remove at the head of a full table
  localparam int WATCHDOG_LIMIT = 2000;
  // quiet cycles let pass before a register write and at the end
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 2 * DEPTH + 8;
  localparam int PHASE_ITEMS    = 200;

  // Shadow copy of the table plus the queue of results still owed by the block.
  class retx_ledger;
    logic [31:0]         seq_mem  [DEPTH];
    logic [31:0]         time_mem [DEPTH];
    logic [TAG_BITS-1:0] tag_mem  [DEPTH];
    int unsigned         held;
    logic [31:0]         timeout_ticks;
    out_item_t           results_due[$];
    int                  errors;

    function void clear_table();
      held          = 0;
      timeout_ticks = TIMEOUT_RST;
      errors        = 0;
    endfunction

    // work out the result of one accepted item and update the shadow table
    function void log_item(in_item_t it);
      out_item_t   res;
      int          hit;
      int unsigned i;
      logic [31:0] age;
      res        = '0;
      res.status = ST_NONE;
      hit        = -1;
      if (it.opcode == OP_ADD) begin
        if (held >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          seq_mem[held]  = it.seq_number;
          time_mem[held] = it.send_time;
          tag_mem[held]  = it.entry_tag[TAG_BITS-1:0];
          res.status     = ST_OK;
          res.out_seq    = it.seq_number;
          res.out_time   = it.send_time;
          res.out_tag    = 16'(tag_mem[held]);
          held++;
        end
      end else begin
        for (i = 0; i < held && hit < 0; i++) begin
          if (it.opcode == OP_TIMEOUT) begin
            age = it.current_time - time_mem[i];
            if (age >= timeout_ticks) hit = i;
          end else if (seq_mem[i] == it.seq_number) begin
            hit = i;
          end
        end
        if (hit >= 0) begin
          res.status   = ST_OK;
          res.out_seq  = seq_mem[hit];
          res.out_time = time_mem[hit];
          res.out_tag  = 16'(tag_mem[hit]);
          if (it.opcode == OP_REMOVE) begin
            for (i = hit; i + 1 < held; i++) begin
              seq_mem[i]  = seq_mem[i+1];
              time_mem[i] = time_mem[i+1];
              tag_mem[i]  = tag_mem[i+1];
            end
            held--;
          end
        end
      end
      res.entries_held = 5'(held);
      results_due.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result %h arrived with nothing outstanding", $time, got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("out_seq", want.out_seq, got.out_seq);
      compare_field("out_time", want.out_time, got.out_time);
      compare_field("out_tag", 32'(want.out_tag), 32'(got.out_tag));
      compare_field("entries_held", 32'(want.entries_held), 32'(got.entries_held));
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel      = 1'b0;
  logic               penable   = 1'b0;
  logic               pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0]        pwdata    = '0;
  logic [31:0]        prdata;
  logic               pready;

  retx_ledger sb = new();

  // when set, neither side inserts gaps or stalls
  bit no_idle = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  retransmit_queue_table i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: a fresh stall count is drawn for every result taken, and
  // counted down on falling edges, so stalls hit idle and busy phases alike.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: sampled at the rising edge, values from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_data);
      stall_left = no_idle ? 0 : $urandom_range(5);
    end
  end

  // Watchdog: any item moving, or a register access, resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one item after a random gap and hold it until taken. Entered and
  // left at a falling edge; in_valid gets at most one assignment per step.
  task automatic send_item(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.log_item(it);
    @(negedge clk);
  endtask

  task automatic send_op(opcode_t op, logic [31:0] seq, logic [31:0] stime,
                         logic [31:0] now, logic [15:0] tag);
    in_item_t it;
    it.opcode       = op;
    it.seq_number   = seq;
    it.send_time    = stime;
    it.current_time = now;
    it.entry_tag    = tag;
    send_item(it);
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write of timeout_ticks followed by a read back of the same register.
  task automatic write_timeout(logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {REG_TIMEOUT, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.timeout_ticks = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      $display("%0t: timeout_ticks read back, expected %h, got %h", $time, value, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random item: mostly well-formed (searches aimed at stored sequence numbers,
  // timeout checks placed on the age boundary of a stored entry), some noise.
  function automatic in_item_t pick_item(int add_pct);
    in_item_t    it;
    int unsigned r;
    int unsigned k;
    it.opcode       = OP_FIND;
    it.seq_number   = $urandom;
    it.send_time    = $urandom;
    it.current_time = $urandom;
    it.entry_tag    = 16'($urandom);
    r = $urandom_range(99);
    if (r < 6) begin
      it.opcode = opcode_t'($urandom_range(3));
    end else if (r < 6 + add_pct) begin
      it.opcode = OP_ADD;
      // a narrow pool of sequence numbers makes duplicates common
      if ($urandom_range(1) == 1) it.seq_number = 32'($urandom_range(7));
    end else begin
      case ($urandom_range(2))
        0:       it.opcode = OP_REMOVE;
        1:       it.opcode = OP_FIND;
        default: it.opcode = OP_TIMEOUT;
      endcase
      if (sb.held > 0 && $urandom_range(9) < 8) begin
        k = $urandom_range(sb.held - 1);
        it.seq_number   = sb.seq_mem[k];
        it.current_time = sb.time_mem[k] + sb.timeout_ticks
                        + 32'($urandom_range(2)) - 32'd1;
      end
    end
    return it;
  endfunction

  task automatic run_phase(int add_pct);
    int k;
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if (k % 40 == 0) no_idle = ($urandom_range(3) == 0);
      // one pause per phase with the pipe fully drained
      if (k == PHASE_ITEMS / 2) drain_results();
      send_item(pick_item(add_pct));
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  initial begin
    int n;
    sb.clear_table();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part, timeout_ticks at its reset value ---
    // searches on an empty table
    send_op(OP_FIND,    32'd0, 32'd0, 32'd0, 16'd0);
    send_op(OP_REMOVE,  32'hFFFF_FFFF, 32'd0, 32'd0, 16'd0);
    send_op(OP_TIMEOUT, 32'd0, 32'd0, 32'hFFFF_FFFF, 16'd0);
    // field extremes and a duplicate sequence number
    send_op(OP_ADD, 32'd0, 32'd0, 32'd0, 16'd0);
    send_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_op(OP_ADD, 32'd5, 32'd100, 32'd0, 16'd1);
    send_op(OP_ADD, 32'd5, 32'd200, 32'd0, 16'd2);
    // duplicates: find and remove act on the oldest one
    send_op(OP_FIND,   32'd5, 32'd0, 32'd0, 16'd0);
    send_op(OP_REMOVE, 32'd5, 32'd0, 32'd0, 16'd0);
    send_op(OP_FIND,   32'd5, 32'd0, 32'd0, 16'd0);
    // age across the time wrap reaches the timeout exactly
    send_op(OP_TIMEOUT, 32'd0, 32'd0, 32'd999, 16'd0);
    // one tick short for every entry
    send_op(OP_TIMEOUT, 32'd0, 32'd0, 32'd998, 16'd0);
    send_op(OP_FIND,    32'd12345, 32'd0, 32'd0, 16'd0);
    // fill the table, then an add on a full table
    for (n = 0; n < DEPTH - 2; n++) begin
      send_op(OP_ADD, 32'($urandom), 32'($urandom), 32'd0, 16'($urandom));
    end
    send_op(OP_ADD, 32'hA5A5_5A5A, 32'h1234_5678, 32'd0, 16'hBEEF);
    // remove at the head of a full table, then at the tail
    send_op(OP_REMOVE, 32'd0, 32'd0, 32'd0, 16'd0);
    send_op(OP_REMOVE, sb.seq_mem[sb.held-1], 32'd0, 32'd0, 16'd0);
    drain_results();

    // timeout zero: every entry is due, the oldest is returned
    write_timeout(32'd0);
    send_op(OP_TIMEOUT, 32'd0, 32'd0, 32'($urandom), 16'd0);
    run_phase(50);

    // largest timeout: only an age of 2^32-1 is due
    write_timeout(32'hFFFF_FFFF);
    run_phase(15);

    write_timeout(32'($urandom_range(5000, 1)));
    run_phase(30);

    write_timeout(32'($urandom));
    run_phase(25);

    // wait for the last owed result, then a quiet tail to catch strays
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.results_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.results_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
